### sv/hicolor_ordered_dither_pack_core_assert.svh
// Assertion macros for the hicolor ordered dither pack core.
`ifndef HICOLOR_ORDERED_DITHER_PACK_CORE_ASSERT_SVH
`define HICOLOR_ORDERED_DITHER_PACK_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HODP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HODP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HODP_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define HODP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/hodp_pkg.sv
// Types, constants and dither tables for the hicolor ordered dither pack core.
package hodp_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned COORD_W  = 3;
    localparam int unsigned SHIFT_W  = 4;
    localparam int unsigned PIX_W    = 16;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN_BIT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT       = 2'd3;

    localparam logic [2:0] OFS_RED   = 3'd0;
    localparam logic [2:0] OFS_GREEN = 3'd2;
    localparam logic [2:0] OFS_BLUE  = 3'd3;

    typedef struct packed {
        logic               sixteen_bit_mode;
        logic [SHIFT_W-1:0] red_shift;
        logic [SHIFT_W-1:0] green_shift;
        logic [SHIFT_W-1:0] blue_shift;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] row_low;
        logic [COORD_W-1:0] column_low;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
    } pixel_in_t;

    function automatic logic [7:0] pattern_row(input logic [2:0] idx);
        logic [7:0] p;
        case (idx)
            3'd0:    p = 8'd16;
            3'd1:    p = 8'd68;
            3'd2:    p = 8'd146;
            3'd3:    p = 8'd170;
            3'd4:    p = 8'd109;
            3'd5:    p = 8'd187;
            3'd6:    p = 8'd239;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

    function automatic logic [2:0] row_perm(input logic [2:0] y);
        logic [2:0] p;
        case (y)
            3'd0:    p = 3'd1;
            3'd1:    p = 3'd5;
            3'd2:    p = 3'd2;
            3'd3:    p = 3'd7;
            3'd4:    p = 3'd4;
            3'd5:    p = 3'd0;
            3'd6:    p = 3'd6;
            default: p = 3'd3;
        endcase
        return p;
    endfunction

endpackage

### sv/hicolor_ordered_dither_pack_core.sv
// Top level of the hicolor ordered dither pack core: RGB888 to RGB555/565 stream.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: red, green, blue, column_low, row_low
//  m_axis    | out       | tdata: packed_pixel
//  cfg       | in        | cfg_index selects mode, red, green, blue shift
//
// Input request to result: input register, dither logic, result register.
// One request per clock sustained while m_tready does not stall; throughput set by the single two-stage pipeline.
// aresetn is synchronous, active low; it empties both stages and restores config defaults.
// A stalled result holds while a new request still fills an empty input stage.
module hicolor_ordered_dither_pack_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // red[7:0], green[15:8], blue[23:16], column_low[26:24], row_low[29:27], zero pad
    input  logic [hodp_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // packed_pixel[15:0]
    output logic [hodp_pkg::PIX_W-1:0]      m_tdata,
    input  logic                            cfg_we,
    input  logic [hodp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hodp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hodp_pkg::*;

`include "hicolor_ordered_dither_pack_core_assert.svh"

    cfg_t              cfg_reg;
    pixel_in_t         in_data_reg;
    logic              in_valid_reg;
    logic [PIX_W-1:0]  out_data_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  dith_pixel;
    logic              advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sixteen_bit_mode <= 1'b1;
            cfg_reg.red_shift        <= 4'd11;
            cfg_reg.green_shift      <= 4'd5;
            cfg_reg.blue_shift       <= 4'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SIXTEEN_BIT_MODE: cfg_reg.sixteen_bit_mode <= cfg_data[0];
                REG_RED_SHIFT:        cfg_reg.red_shift        <= cfg_data[SHIFT_W-1:0];
                REG_GREEN_SHIFT:      cfg_reg.green_shift      <= cfg_data[SHIFT_W-1:0];
                REG_BLUE_SHIFT:       cfg_reg.blue_shift       <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= pixel_in_t'(s_tdata[$bits(pixel_in_t)-1:0]);
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= dith_pixel;
        end
    end

    hodp_dither u_dither (
        .pix_in       (in_data_reg),
        .cfg          (cfg_reg),
        .packed_pixel (dith_pixel)
    );

    `HODP_ASSERT_SAME(a_stall_only_full, aclk, aresetn, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready)
    `HODP_ASSERT_NEXT(a_stage_moves, aclk, aresetn, in_valid_reg && advance, m_tvalid)
    `HODP_ASSERT_NEXT(a_out_drains, aclk, aresetn,
        m_tvalid && m_tready && !in_valid_reg, !m_tvalid)

endmodule

### sv/hodp_dither.sv
// Per-pixel ordered dither, saturation and field packing.
module hodp_dither (
    input  hodp_pkg::pixel_in_t         pix_in,
    input  hodp_pkg::cfg_t              cfg,
    output logic [hodp_pkg::PIX_W-1:0]  packed_pixel
);
    import hodp_pkg::*;

    logic [2:0] base_pos;
    logic [2:0] pos_r, pos_g, pos_b;
    logic [2:0] rem_r, rem_b, rem_g;
    logic [2:0] idx_r, idx_b, idx_g;
    logic [7:0] row_r, row_b, row_g;
    logic       bit_r, bit_b, bit_g;
    logic [5:0] base_r, base_b, base_g;
    logic [6:0] sum_r, sum_b, sum_g;
    logic [5:0] lim_g;
    logic [5:0] rr, gg, bb;

    always_comb begin
        base_pos = pix_in.column_low + row_perm(pix_in.row_low);
        pos_r    = base_pos + OFS_RED;
        pos_g    = base_pos + OFS_GREEN;
        pos_b    = base_pos + OFS_BLUE;

        rem_r  = pix_in.red[2:0];
        rem_b  = pix_in.blue[2:0];
        idx_r  = rem_r - 3'd1;
        idx_b  = rem_b - 3'd1;
        base_r = {1'b0, pix_in.red[7:3]};
        base_b = {1'b0, pix_in.blue[7:3]};

        if (cfg.sixteen_bit_mode) begin
            rem_g  = {1'b0, pix_in.green[1:0]};
            idx_g  = {pix_in.green[1:0], 1'b0} - 3'd1;
            base_g = pix_in.green[7:2];
            lim_g  = 6'd63;
        end else begin
            rem_g  = pix_in.green[2:0];
            idx_g  = rem_g - 3'd1;
            base_g = {1'b0, pix_in.green[7:3]};
            lim_g  = 6'd31;
        end

        row_r = pattern_row(idx_r);
        row_g = pattern_row(idx_g);
        row_b = pattern_row(idx_b);
        bit_r = (rem_r != 3'd0) && row_r[pos_r];
        bit_g = (rem_g != 3'd0) && row_g[pos_g];
        bit_b = (rem_b != 3'd0) && row_b[pos_b];

        sum_r = {1'b0, base_r} + {6'd0, bit_r};
        sum_g = {1'b0, base_g} + {6'd0, bit_g};
        sum_b = {1'b0, base_b} + {6'd0, bit_b};

        rr = (sum_r > 7'd31) ? 6'd31 : sum_r[5:0];
        bb = (sum_b > 7'd31) ? 6'd31 : sum_b[5:0];
        gg = (sum_g > {1'b0, lim_g}) ? lim_g : sum_g[5:0];

        packed_pixel = ({10'd0, rr} << cfg.red_shift)
                     | ({10'd0, gg} << cfg.green_shift)
                     | ({10'd0, bb} << cfg.blue_shift);
    end

endmodule

### verif/hodp_pixel_checker.sv
// Checker for the ordered dither pack core: predicts each packed pixel and compares results.
module hodp_pixel_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // red[7:0], green[15:8], blue[23:16], column_low[26:24], row_low[29:27], zero pad
    input  logic [hodp_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // packed_pixel[15:0]
    input  logic [hodp_pkg::PIX_W-1:0]      m_tdata,
    input  logic                            cfg_we,
    input  logic [hodp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hodp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import hodp_pkg::*;

    localparam logic [6:0][7:0] DITHER_ROWS =
        {8'd239, 8'd187, 8'd109, 8'd170, 8'd146, 8'd68, 8'd16};
    localparam logic [7:0][2:0] ROW_SHUFFLE =
        {3'd3, 3'd6, 3'd0, 3'd4, 3'd7, 3'd2, 3'd5, 3'd1};

    cfg_t             cfg;
    logic [PIX_W-1:0] expected_pixels[$];
    logic [PIX_W-1:0] oldest;
    pixel_in_t        in_pixel;

    function automatic logic [6:0] dither_channel_value(input logic [5:0] base,
                                                        input logic [2:0] rem,
                                                        input logic [2:0] row_sel,
                                                        input logic [2:0] pos,
                                                        input logic [6:0] ceiling);
        logic [6:0] v;
        v = {1'b0, base};
        if (rem != 3'd0) begin
            v = v + 7'(DITHER_ROWS[row_sel][pos]);
        end
        if (v > ceiling) begin
            v = ceiling;
        end
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] dither_pixel(input pixel_in_t p, input cfg_t c);
        logic [2:0]  base_pos;
        logic [6:0]  rr;
        logic [6:0]  gg;
        logic [6:0]  bb;
        logic [31:0] word;
        base_pos = p.column_low + ROW_SHUFFLE[p.row_low];
        rr = dither_channel_value({1'b0, p.red[7:3]}, p.red[2:0], p.red[2:0] - 3'd1,
                                  base_pos + OFS_RED, 7'd31);
        bb = dither_channel_value({1'b0, p.blue[7:3]}, p.blue[2:0], p.blue[2:0] - 3'd1,
                                  base_pos + OFS_BLUE, 7'd31);
        if (c.sixteen_bit_mode) begin
            // 6-bit green: 2-bit remainder picks every other pattern row
            gg = dither_channel_value(p.green[7:2], {1'b0, p.green[1:0]},
                                      {p.green[1:0], 1'b0} - 3'd1,
                                      base_pos + OFS_GREEN, 7'd63);
        end else begin
            gg = dither_channel_value({1'b0, p.green[7:3]}, p.green[2:0],
                                      p.green[2:0] - 3'd1, base_pos + OFS_GREEN, 7'd31);
        end
        word = (32'(rr) << c.red_shift) | (32'(gg) << c.green_shift)
             | (32'(bb) << c.blue_shift);
        return word[PIX_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.sixteen_bit_mode = 1'b1;
            cfg.red_shift        = 4'd11;
            cfg.green_shift      = 4'd5;
            cfg.blue_shift       = 4'd0;
            expected_pixels.delete();
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SIXTEEN_BIT_MODE: cfg.sixteen_bit_mode = cfg_data[0];
                    REG_RED_SHIFT:        cfg.red_shift        = cfg_data;
                    REG_GREEN_SHIFT:      cfg.green_shift      = cfg_data;
                    REG_BLUE_SHIFT:       cfg.blue_shift       = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                in_pixel = s_tdata[$bits(pixel_in_t)-1:0];
                expected_pixels.push_back(dither_pixel(in_pixel, cfg));
            end
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: packed pixel %h with no request pending", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    oldest = expected_pixels.pop_front();
                    if (m_tdata !== oldest) begin
                        $display("%0t: packed pixel mismatch, expected %h actual %h",
                                 $time, oldest, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

### verif/tb_hicolor_ordered_dither_pack_core.sv
// Testbench top for the ordered dither pack core: stimulus, config phases and verdict.
module tb_hicolor_ordered_dither_pack_core;
    import hodp_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 80;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [PIX_W-1:0]      m_tdata;
    int                    fail_count;
    int                    pending;
    int                    quiet_cycles = 0;
    bit                    idle_en      = 1'b1;
    bit                    hold_off_req = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    hicolor_ordered_dither_pack_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hodp_pixel_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 10);
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                gap = $urandom_range(1, 12);
                repeat (gap) @(posedge aclk);
            end
        end
    end

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(248, 255));
            1:       return 8'($urandom_range(0, 7));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input pixel_in_t p);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(p);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        pixel_in_t p;
        repeat (count) begin
            p.red        = random_channel();
            p.green      = random_channel();
            p.blue       = random_channel();
            p.column_low = 3'($urandom);
            p.row_low    = 3'($urandom);
            send_pixel(p);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] mode_data,
                                input logic [CFG_DATA_W-1:0] red_pos,
                                input logic [CFG_DATA_W-1:0] green_pos,
                                input logic [CFG_DATA_W-1:0] blue_pos);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SIXTEEN_BIT_MODE;
        cfg_data  <= mode_data;
        @(posedge aclk);
        cfg_index <= REG_RED_SHIFT;
        cfg_data  <= red_pos;
        @(posedge aclk);
        cfg_index <= REG_GREEN_SHIFT;
        cfg_data  <= green_pos;
        @(posedge aclk);
        cfg_index <= REG_BLUE_SHIFT;
        cfg_data  <= blue_pos;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        pixel_in_t p;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting, 5-6-5: extremes, every remainder, saturation near full scale
        send_pixel('0);
        send_pixel('1);
        for (int k = 0; k < 8; k++) begin
            p.red        = 8'hf8 | 8'(k);
            p.green      = 8'hf8 | 8'(k);
            p.blue       = 8'hf8 | 8'(7 - k);
            p.column_low = 3'(k);
            p.row_low    = 3'(7 - k);
            send_pixel(p);
        end
        for (int k = 0; k < 8; k++) begin
            p.red        = 8'(k);
            p.green      = 8'(k);
            p.blue       = 8'(k);
            p.column_low = 3'(7 - k);
            p.row_low    = 3'(k);
            send_pixel(p);
        end
        send_random(250);
        drain();

        // 5-5-5, with a long result stall in the middle
        write_config(4'b1110, 4'd10, 4'd5, 4'd0);
        send_random(50);
        hold_off_req = 1'b1;
        send_random(200);
        drain();

        // fields pushed past bit 15
        write_config(4'b0001, 4'd15, 4'd15, 4'd15);
        send_random(200);
        drain();

        // fully overlapping fields
        write_config(4'b0000, 4'd0, 4'd0, 4'd0);
        send_random(200);
        drain();

        write_config(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
        send_random(200);
        drain();

        idle_en = 1'b0;
        write_config(4'b1111, 4'd11, 4'd5, 4'd0);
        send_random(150);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
